// ===== rtl/shb_pkg.sv =====
`timescale 1ns / 1ps
package shb_pkg;

	localparam int MAX_BINS_DEF    = 32;
	localparam int WEIGHT_BITS_DEF = 40;

	// max_bins register value after reset
	localparam logic [6:0] MAX_BINS_RST = 7'd32;

	// largest value on the 16-fraction-bit sum path
	localparam logic [63:0] FIX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// quotient and divisor widths of the shared divider
	localparam int QUO_W = 64;
	localparam int DEN_W = 66;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUM  = 2'd1,
		OP_DUMP = 2'd2
	} opcode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ASCAN_RD,
		ST_ASCAN_EV,
		ST_UP_RD,
		ST_UP_WR,
		ST_INS_WR,
		ST_TRIM,
		ST_GAP_RD,
		ST_GAP_EV,
		ST_MRG_RD0,
		ST_MRG_RD1,
		ST_MRG_SET,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_MRG_WR,
		ST_DN_RD,
		ST_DN_WR,
		ST_SSCAN_RD,
		ST_SSCAN_EV,
		ST_SALL,
		ST_SUMFIN,
		ST_RESULT,
		ST_DUMP_RD,
		ST_DUMP_EM
	} state_t;

	// products formed by the shift-add multiplier
	typedef enum logic [2:0] {
		PH_U,
		PH_V,
		PH_T,
		PH_N,
		PH_D,
		PH_MRG
	} mphase_t;

endpackage

// ===== rtl/streaming_histogram_bins_unit.sv =====
`timescale 1ns / 1ps
// Streaming histogram: a table of up to MAX_BINS bins sorted by centroid
// (signed Q16.16) with saturating weights, held in two single-port memories
// (centroids and weights) with a registered read. Opcode 0 adds a weighted
// point (exact position adds to that bin, otherwise a new bin is inserted and
// the closest adjacent pairs are merged until at most max_bins remain),
// opcode 1 returns the interpolated weight at or below a bound, opcode 2
// streams out every bin in ascending order; each request yields one result
// (a dump yields one per bin). Requests are handled one at a time: s_axis_tready
// is high only while the block is idle. Every table read is registered, so
// an add's time grows with the bins scanned and the bins moved; each merge
// adds a gap search over the bins, a shift-add multiply, a bit-serial divide
// and the bins moved. A sum query scans the bins, then runs up to five
// shift-add multiplies, a bit-serial divide and a final combine; a dump reads
// and emits one bin at a time and waits while the output is stalled.
// max_bins is written through cfg_we and is clamped to 1..MAX_BINS; lowering
// it trims the table at the next insertion.
module streaming_histogram_bins_unit
	import shb_pkg::*;
#(
	parameter int MAX_BINS    = MAX_BINS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: max_bins
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	// request stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // value[31:0], weight[63:32]
	input  logic [1:0]   s_axis_tuser,   // opcode[1:0]
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,   // sum_value[62:0], bin_position[94:63],
	                                     // bin_weight[134:95], bins_in_use[141:135]
	output logic         m_axis_tlast    // last
);

	localparam int CAP   = MAX_BINS + 1;
	localparam int AW    = $clog2(CAP);
	localparam int CW    = $clog2(CAP + 1);
	localparam int W     = WEIGHT_BITS;
	localparam int NUM_W = W + 82;
	localparam logic [63:0] WMAX64 = (64'd1 << W) - 64'd1;
	localparam logic [6:0]  MAX_B7 = 7'(MAX_BINS);

	// table memories
	logic signed [31:0] cen_mem [CAP];
	logic [W-1:0]       wt_mem  [CAP];

	state_t state_q, state_d;

	// request and control
	opcode_t            op_q;
	logic signed [31:0] val_q;
	logic [W-1:0]       wgt_q;
	logic [6:0]         max_bins_q;
	logic [CW-1:0]      total_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      j_q;
	logic [AW-1:0]      at_q;

	// memory read data
	logic signed [31:0] rd_c_q;
	logic [W-1:0]       rd_w_q;

	// gap search and merge
	logic signed [31:0] prev_q;
	logic [32:0]        best_q;
	logic signed [31:0] q1_q;
	logic [W-1:0]       wsum_q;

	// sum query
	logic signed [31:0] cj_q;
	logic [W-1:0]       pcw_q;
	logic [63:0]        pre_q;
	logic [63:0]        r_q;
	logic [32:0]        x_q;
	logic [32:0]        d_q;
	logic [1:0]         fin_q;

	// shift-add multiplier
	logic [NUM_W-1:0]   acc_q;
	logic [NUM_W-1:0]   a_q;
	logic [32:0]        b_q;
	logic [NUM_W-1:0]   hold_q;
	mphase_t            ph_q;

	// bit-serial divider
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [6:0]         dcnt_q;
	logic               sat_q;

	// output register
	logic               ov_q;
	logic [62:0]        osum_q;
	logic signed [31:0] opos_q;
	logic [39:0]        owt_q;
	logic [6:0]         ouse_q;
	logic               olast_q;

	// memory port
	logic               re, we;
	logic [AW-1:0]      ra, wa;
	logic signed [31:0] wc;
	logic [W-1:0]       ww;

	function automatic logic [W-1:0] wsat(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[W] ? {W{1'b1}} : s[W-1:0];
	endfunction

	function automatic logic [63:0] usat(input logic [63:0] a, input logic [W-1:0] b);
		logic [64:0] s;
		s = {1'b0, a} + 65'(b);
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [63:0] fix_of(input logic [63:0] v);
		return (v[63:47] != '0) ? FIX_MAX : {v[47:0], 16'd0};
	endfunction

	function automatic logic [63:0] fix_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, FIX_MAX}) ? FIX_MAX : s[63:0];
	endfunction

	// effective bin limit and helpers
	logic [6:0]       eff;
	logic             trim_need;
	logic             out_free;
	logic             load_out;
	logic             ins_ok;
	logic [63:0]      wgt_wide;
	logic [W-1:0]     wgt_clamp;
	logic [32:0]      gap;
	logic [32:0]      diff_raw;
	logic [32:0]      diff;
	logic [32:0]      x_new;
	logic [NUM_W-1:0] hi;
	logic [DEN_W:0]   r2;
	logic             r2_ge;
	logic [63:0]      off;
	logic [33:0]      pos_raw;
	logic [33:0]      pos;
	logic [63:0]      fmin;
	logic             dump_last;

	always_comb begin
		if (max_bins_q == 7'd0) begin
			eff = 7'd1;
		end else if (max_bins_q > MAX_B7) begin
			eff = MAX_B7;
		end else begin
			eff = max_bins_q;
		end
	end

	assign trim_need = (7'(total_q) > eff) && (total_q >= CW'(2));
	assign out_free  = !ov_q || m_axis_tready;
	assign load_out  = ((state_q == ST_RESULT) || (state_q == ST_DUMP_EM)) && out_free;
	assign ins_ok    = total_q < CW'(CAP);
	assign dump_last = (idx_q + CW'(1)) == total_q;

	// incoming weight clamped to the weight range
	assign wgt_wide  = 64'(s_axis_tdata[63:32]);
	assign wgt_clamp = (wgt_wide > WMAX64) ? {W{1'b1}} : W'(wgt_wide);

	// gap between neighbors and centroid differences, all 33-bit
	assign gap      = {rd_c_q[31], rd_c_q} - {prev_q[31], prev_q};
	assign diff_raw = {rd_c_q[31], rd_c_q} - {q1_q[31], q1_q};
	assign diff     = diff_raw[32] ? 33'd0 : diff_raw;
	assign x_new    = {val_q[31], val_q} - {cj_q[31], cj_q};

	// divider step
	assign hi    = hold_q >> QUO_W;
	assign r2    = {rem_q, quo_q[QUO_W-1]};
	assign r2_ge = r2 >= {1'b0, den_q};

	// merged centroid: truncate toward zero
	assign off     = (quo_q > 64'(d_q)) ? 64'(d_q) : quo_q;
	assign pos_raw = {q1_q[31], q1_q[31], q1_q} + {1'b0, off[32:0]};
	assign pos     = ((sat_q || (rem_q != '0)) && pos_raw[33]) ? pos_raw + 34'd1 : pos_raw;

	assign fmin = (quo_q > FIX_MAX) ? FIX_MAX : quo_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (op_q)
					OP_ADD:  state_d = (wgt_q == '0) ? ST_RESULT : ST_ASCAN_RD;
					OP_SUM:  state_d = (total_q == '0) ? ST_RESULT : ST_SSCAN_RD;
					OP_DUMP: state_d = (total_q == '0) ? ST_RESULT : ST_DUMP_RD;
					default: state_d = ST_RESULT;
				endcase
			end
			ST_ASCAN_RD: begin
				if (idx_q == total_q) begin
					state_d = ins_ok ? ST_UP_RD : ST_RESULT;
				end else begin
					state_d = ST_ASCAN_EV;
				end
			end
			ST_ASCAN_EV: begin
				if (rd_c_q == val_q) begin
					state_d = ST_RESULT;
				end else if (rd_c_q > val_q) begin
					state_d = ins_ok ? ST_UP_RD : ST_RESULT;
				end else begin
					state_d = ST_ASCAN_RD;
				end
			end
			ST_UP_RD:    state_d = (j_q == idx_q) ? ST_INS_WR : ST_UP_WR;
			ST_UP_WR:    state_d = ST_UP_RD;
			ST_INS_WR:   state_d = ST_TRIM;
			ST_TRIM:     state_d = trim_need ? ST_GAP_RD : ST_RESULT;
			ST_GAP_RD:   state_d = ST_GAP_EV;
			ST_GAP_EV:   state_d = dump_last ? ST_MRG_RD0 : ST_GAP_RD;
			ST_MRG_RD0:  state_d = ST_MRG_RD1;
			ST_MRG_RD1:  state_d = ST_MRG_SET;
			ST_MRG_SET:  state_d = ST_MUL;
			ST_MUL: begin
				if ((b_q == '0) && ((ph_q == PH_D) || (ph_q == PH_MRG))) begin
					state_d = ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (dcnt_q == '0) begin
					state_d = (ph_q == PH_MRG) ? ST_MRG_WR : ST_SUMFIN;
				end
			end
			ST_MRG_WR:   state_d = ST_DN_RD;
			ST_DN_RD:    state_d = ((j_q + CW'(1)) >= total_q) ? ST_TRIM : ST_DN_WR;
			ST_DN_WR:    state_d = ST_DN_RD;
			ST_SSCAN_RD: state_d = (idx_q == total_q) ? ST_SALL : ST_SSCAN_EV;
			ST_SSCAN_EV: begin
				if (idx_q == '0) begin
					state_d = (val_q < rd_c_q) ? ST_RESULT : ST_SSCAN_RD;
				end else begin
					state_d = (rd_c_q <= val_q) ? ST_SSCAN_RD : ST_MUL;
				end
			end
			ST_SALL:     state_d = ST_RESULT;
			ST_SUMFIN:   state_d = (fin_q == 2'd2) ? ST_RESULT : ST_SUMFIN;
			ST_RESULT:   state_d = out_free ? ST_IDLE : ST_RESULT;
			ST_DUMP_RD:  state_d = ST_DUMP_EM;
			ST_DUMP_EM: begin
				if (out_free) begin
					state_d = dump_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		re = 1'b0;
		ra = '0;
		we = 1'b0;
		wa = '0;
		wc = rd_c_q;
		ww = rd_w_q;
		unique case (state_q)
			ST_ASCAN_RD, ST_GAP_RD, ST_SSCAN_RD, ST_DUMP_RD: begin
				re = 1'b1;
				ra = idx_q[AW-1:0];
			end
			ST_UP_RD: begin
				// no read once the insertion slot is reached
				re = (j_q != idx_q);
				ra = AW'(j_q - CW'(1));
			end
			ST_MRG_RD0: begin
				re = 1'b1;
				ra = at_q;
			end
			ST_MRG_RD1: begin
				re = 1'b1;
				ra = at_q + AW'(1);
			end
			ST_DN_RD: begin
				re = 1'b1;
				ra = AW'(j_q + CW'(1));
			end
			ST_ASCAN_EV: begin
				// exact position: weight goes into the existing bin
				we = (rd_c_q == val_q);
				wa = idx_q[AW-1:0];
				ww = wsat(rd_w_q, wgt_q);
			end
			ST_UP_WR, ST_DN_WR: begin
				we = 1'b1;
				wa = j_q[AW-1:0];
			end
			ST_INS_WR: begin
				we = 1'b1;
				wa = idx_q[AW-1:0];
				wc = val_q;
				ww = wgt_q;
			end
			ST_MRG_WR: begin
				we = 1'b1;
				wa = at_q;
				wc = pos[31:0];
				ww = wsum_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			cen_mem[wa] <= wc;
			wt_mem[wa]  <= ww;
		end
		if (re) begin
			rd_c_q <= cen_mem[ra];
			rd_w_q <= wt_mem[ra];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_bins_q <= MAX_BINS_RST;
			total_q    <= '0;
			ov_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				max_bins_q <= cfg_wdata;
			end
			if (state_q == ST_INS_WR) begin
				total_q <= total_q + CW'(1);
			end else if ((state_q == ST_DN_RD) && ((j_q + CW'(1)) >= total_q)) begin
				total_q <= total_q - CW'(1);
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					op_q  <= opcode_t'(s_axis_tuser);
					val_q <= s_axis_tdata[31:0];
					wgt_q <= wgt_clamp;
				end
			end
			ST_DECODE: begin
				idx_q <= '0;
				r_q   <= '0;
				pre_q <= '0;
			end
			ST_ASCAN_RD: begin
				j_q <= total_q;
			end
			ST_ASCAN_EV: begin
				j_q <= total_q;
				if (rd_c_q < val_q) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_UP_WR: begin
				j_q <= j_q - CW'(1);
			end
			ST_TRIM: begin
				idx_q <= '0;
			end
			ST_GAP_EV: begin
				prev_q <= rd_c_q;
				idx_q  <= idx_q + CW'(1);
				// first pair seeds the search, later pairs win only on a strictly smaller gap
				if ((idx_q == CW'(1)) || ((idx_q != '0) && (gap < best_q))) begin
					best_q <= gap;
					at_q   <= AW'(idx_q - CW'(1));
				end
			end
			ST_MRG_RD1: begin
				q1_q   <= rd_c_q;
				wsum_q <= rd_w_q;
			end
			ST_MRG_SET: begin
				den_q  <= DEN_W'(wsum_q) + DEN_W'(rd_w_q);
				wsum_q <= wsat(wsum_q, rd_w_q);
				d_q    <= diff;
				a_q    <= NUM_W'(rd_w_q);
				b_q    <= diff;
				acc_q  <= '0;
				ph_q   <= PH_MRG;
			end
			ST_MUL: begin
				if (b_q != '0) begin
					if (b_q[0]) begin
						acc_q <= acc_q + a_q;
					end
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end else begin
					case (ph_q)
						PH_U: begin
							a_q   <= acc_q;
							b_q   <= x_q;
							acc_q <= '0;
							ph_q  <= PH_V;
						end
						PH_V: begin
							hold_q <= acc_q;
							a_q    <= NUM_W'(pcw_q);
							b_q    <= x_q;
							acc_q  <= '0;
							ph_q   <= PH_T;
						end
						PH_T: begin
							a_q   <= acc_q;
							b_q   <= 33'({d_q, 1'b0} - {1'b0, x_q});
							acc_q <= hold_q;
							ph_q  <= PH_N;
						end
						PH_N: begin
							hold_q <= acc_q << 16;
							a_q    <= NUM_W'(d_q);
							b_q    <= d_q;
							acc_q  <= '0;
							ph_q   <= PH_D;
						end
						PH_D: begin
							den_q <= {acc_q[DEN_W-2:0], 1'b0};
						end
						PH_MRG: begin
							hold_q <= acc_q;
						end
						default: begin
						end
					endcase
				end
			end
			ST_DIV_INIT: begin
				fin_q <= '0;
				if (hi >= NUM_W'(den_q)) begin
					quo_q  <= '1;
					rem_q  <= '0;
					sat_q  <= 1'b1;
					dcnt_q <= '0;
				end else begin
					quo_q  <= hold_q[QUO_W-1:0];
					rem_q  <= hi[DEN_W-1:0];
					sat_q  <= 1'b0;
					dcnt_q <= 7'(QUO_W);
				end
			end
			ST_DIV: begin
				if (dcnt_q != '0) begin
					rem_q  <= r2_ge ? DEN_W'(r2 - {1'b0, den_q}) : r2[DEN_W-1:0];
					quo_q  <= {quo_q[QUO_W-2:0], r2_ge};
					dcnt_q <= dcnt_q - 7'd1;
				end
			end
			ST_MRG_WR: begin
				j_q <= CW'(at_q) + CW'(1);
			end
			ST_DN_WR: begin
				j_q <= j_q + CW'(1);
			end
			ST_SSCAN_RD: begin
				if (idx_q == total_q) begin
					pre_q <= usat(pre_q, pcw_q);
				end
			end
			ST_SSCAN_EV: begin
				if (idx_q == '0) begin
					cj_q  <= rd_c_q;
					pcw_q <= rd_w_q;
					idx_q <= CW'(1);
				end else if (rd_c_q <= val_q) begin
					pre_q <= usat(pre_q, pcw_q);
					cj_q  <= rd_c_q;
					pcw_q <= rd_w_q;
					idx_q <= idx_q + CW'(1);
				end else begin
					// bound falls between two bins: interpolate
					x_q   <= x_new;
					d_q   <= {rd_c_q[31], rd_c_q} - {cj_q[31], cj_q};
					r_q   <= fix_of(pre_q);
					a_q   <= NUM_W'(rd_w_q);
					b_q   <= x_new;
					acc_q <= '0;
					ph_q  <= PH_U;
				end
			end
			ST_SALL: begin
				r_q <= fix_of(pre_q);
			end
			ST_SUMFIN: begin
				fin_q <= fin_q + 2'd1;
				case (fin_q)
					2'd0:    r_q <= fix_add(r_q, fix_of(64'(pcw_q >> 1)));
					2'd1:    r_q <= fix_add(r_q, {48'd0, pcw_q[0], 15'd0});
					default: r_q <= fix_add(r_q, fmin);
				endcase
			end
			ST_DUMP_EM: begin
				if (out_free) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			default: begin
			end
		endcase

		if (load_out) begin
			osum_q  <= ((state_q == ST_RESULT) && (op_q == OP_SUM)) ? r_q[62:0] : '0;
			opos_q  <= (state_q == ST_DUMP_EM) ? rd_c_q : '0;
			owt_q   <= (state_q == ST_DUMP_EM) ? 40'(rd_w_q) : '0;
			ouse_q  <= 7'(total_q);
			olast_q <= (state_q == ST_RESULT) || dump_last;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {2'b00, ouse_q, owt_q, opos_q, osum_q};
	assign m_axis_tlast  = olast_q;

	// table never holds more than one bin past MAX_BINS
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(CAP))
		else $error("bin count beyond table capacity");

	// merged centroid offset stays within the pair
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRG_WR) |-> (quo_q <= 64'(d_q)))
		else $error("merge offset exceeds centroid gap");

	// a result only appears while a request is being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) != ST_IDLE))
		else $error("result without a request");

endmodule
